@@ rtl/core/dnc_pkg.sv @@
// ----------------------------------------------------------------------------
// dnc_pkg
// Shared types and constants for the domain name checker: register
// indexes, reset values of the TLD words, result class codes and the
// summary that the name tracker hands to the result stage.
// ----------------------------------------------------------------------------
package dnc_pkg;

    localparam int CHAR_W    = 8;
    localparam int WORD_W    = 32;
    localparam int CFG_IDX_W = 3;
    localparam int NUM_CORE  = 4;
    localparam int NUM_RESTR = 3;
    localparam int NUM_CFG   = NUM_CORE + NUM_RESTR;

    typedef logic [WORD_W-1:0] word_t;
    typedef logic [CHAR_W-1:0] char_t;

    // Register indexes on the configuration port
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_CORE_TLD_0       = 3'd0,
        CFG_CORE_TLD_1       = 3'd1,
        CFG_CORE_TLD_2       = 3'd2,
        CFG_CORE_TLD_3       = 3'd3,
        CFG_RESTRICTED_TLD_0 = 3'd4,
        CFG_RESTRICTED_TLD_1 = 3'd5,
        CFG_RESTRICTED_TLD_2 = 3'd6
    } cfg_index_t;

    // First restricted word in the register file
    localparam cfg_index_t CFG_FIRST_RESTR = CFG_RESTRICTED_TLD_0;
    localparam cfg_index_t CFG_LAST        = CFG_RESTRICTED_TLD_2;

    // Reset contents: com, net, org, info, biz, name, pro
    localparam word_t CFG_RESET [NUM_CFG] = '{
        32'h636F_6D00, 32'h6E65_7400, 32'h6F72_6700, 32'h696E_666F,
        32'h6269_7A00, 32'h6E61_6D65, 32'h7072_6F00
    };

    // Result classes
    typedef enum logic [1:0] {
        TLD_OTHER      = 2'd0,
        TLD_CORE       = 2'd1,
        TLD_RESTRICTED = 2'd2
    } tld_class_t;

    // ASCII codes used by the byte checks
    localparam char_t CH_DASH   = 8'h2D;
    localparam char_t CH_PERIOD = 8'h2E;
    localparam char_t CH_UPPER_A = 8'h41;
    localparam char_t CH_UPPER_Z = 8'h5A;
    localparam char_t CH_LOWER_A = 8'h61;
    localparam char_t CH_LOWER_Z = 8'h7A;
    localparam char_t CH_DIGIT_0 = 8'h30;
    localparam char_t CH_DIGIT_9 = 8'h39;
    localparam char_t CASE_BIT   = 8'h20;

    // Final verdict on one name, from tracker to result stage
    typedef struct packed {
        logic  fire;
        logic  name_ok;
        logic  matchable;
        word_t tld_word;
    } dnc_summary_t;

endpackage

@@ rtl/core/dnc_char_if.sv @@
// ----------------------------------------------------------------------------
// dnc_char_if
// Byte channel into the checker: one name byte and its last flag.
// ----------------------------------------------------------------------------
interface dnc_char_if;

    logic                valid;
    logic                ready;
    dnc_pkg::char_t      char_in;
    logic                last_char;

    modport source (output valid, output char_in, output last_char, input ready);
    modport sink   (input valid, input char_in, input last_char, output ready);

endinterface

@@ rtl/core/dnc_result_if.sv @@
// ----------------------------------------------------------------------------
// dnc_result_if
// Result channel out of the checker: validity and TLD class of one name.
// ----------------------------------------------------------------------------
interface dnc_result_if;

    logic       valid;
    logic       ready;
    logic       name_valid;
    logic [1:0] tld_class;

    modport source (output valid, output name_valid, output tld_class, input ready);
    modport sink   (input valid, input name_valid, input tld_class, output ready);

endinterface

@@ rtl/core/domain_name_checker.sv @@
// ----------------------------------------------------------------------------
// domain_name_checker
// Streams domain names byte by byte and reports, per name, whether the
// syntax holds and whether its TLD is a configured core or restricted word.
//
//   port      dir   carries
//   chars     in    char_in[7:0], last_char   (valid/ready)
//   results   out   name_valid, tld_class[1:0] (valid/ready), one per name
//   cfg_*     in    write enable, index[2:0], data[31:0]
//
// One byte per cycle when not stalled; a name's result passes through the
// input register, then the result register.
// The only stall source is a last byte meeting a full result register.
// Reset clears the handshake state and the per-name state and loads the
// default TLD words; no clearing pass is needed.
// ----------------------------------------------------------------------------
module domain_name_checker #(
    parameter int MAX_LABEL_LEN = 63,
    parameter int TLD_MAX_CHARS = 4
) (
    input  logic                          clk,
    input  logic                          rst_n,
    dnc_char_if.sink                      chars,
    dnc_result_if.source                  results,
    input  logic                          cfg_wr_en,
    input  logic [dnc_pkg::CFG_IDX_W-1:0] cfg_index,
    input  dnc_pkg::word_t                cfg_wdata
);
    import dnc_pkg::*;

    word_t        cfg_words [NUM_CFG];
    dnc_summary_t summary;
    tld_class_t   class_comb;
    logic         out_free;

    logic         out_valid_reg, out_valid_next;
    logic         out_name_valid_reg;
    tld_class_t   out_class_reg;

    dnc_cfg_regs u_cfg_regs (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg_words (cfg_words)
    );

    dnc_name_tracker #(
        .MAX_LABEL_LEN (MAX_LABEL_LEN),
        .TLD_MAX_CHARS (TLD_MAX_CHARS)
    ) u_tracker (
        .clk      (clk),
        .rst_n    (rst_n),
        .chars    (chars),
        .out_free (out_free),
        .summary  (summary)
    );

    dnc_tld_match u_match (
        .cfg_words (cfg_words),
        .tld_word  (summary.tld_word),
        .matchable (summary.matchable),
        .tld_class (class_comb)
    );

    // Result register takes a new item when empty or being drained
    assign out_free = !out_valid_reg || results.ready;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (summary.fire)
        begin
            out_valid_next = 1'b1;
        end
        else if (results.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    // Load result payload
    always_ff @(posedge clk)
    begin
        if (summary.fire)
        begin
            out_name_valid_reg <= summary.name_ok;
            out_class_reg      <= class_comb;
        end
    end

    assign results.valid      = out_valid_reg;
    assign results.name_valid = out_name_valid_reg;
    assign results.tld_class  = out_class_reg;

`ifndef ASSERT_OFF
    a_class_needs_valid: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && (out_class_reg != TLD_OTHER)) |-> out_name_valid_reg)
        else $error("TLD class reported for an invalid name");
    a_fire_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        summary.fire |=> out_valid_reg)
        else $error("closed name produced no result");
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        summary.fire |-> out_free)
        else $error("result overwritten before it was taken");
`endif

endmodule

@@ rtl/core/dnc_cfg_regs.sv @@
// ----------------------------------------------------------------------------
// dnc_cfg_regs
// Register file for the core and restricted TLD words, written through a
// plain write port; indexes past the last register are ignored.
// ----------------------------------------------------------------------------
module dnc_cfg_regs (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_wr_en,
    input  logic [dnc_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  dnc_pkg::word_t                    cfg_wdata,
    output dnc_pkg::word_t                    cfg_words [dnc_pkg::NUM_CFG]
);
    import dnc_pkg::*;

    word_t words_reg [NUM_CFG];

    // Write one word per enabled cycle
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_CFG; i++)
            begin
                words_reg[i] <= CFG_RESET[i];
            end
        end
        else if (cfg_wr_en && (cfg_index <= CFG_LAST))
        begin
            words_reg[cfg_index] <= cfg_wdata;
        end
    end

    assign cfg_words = words_reg;

endmodule

@@ rtl/core/dnc_name_tracker.sv @@
// ----------------------------------------------------------------------------
// dnc_name_tracker
// Input register and per-name state. Each byte is folded to lower case and
// checked against the label and TLD rules; on the last byte the verdict is
// handed on and the per-name state returns to its start values.
// ----------------------------------------------------------------------------
module dnc_name_tracker #(
    parameter int MAX_LABEL_LEN = 63,
    parameter int TLD_MAX_CHARS = 4
) (
    input  logic                  clk,
    input  logic                  rst_n,
    dnc_char_if.sink              chars,
    input  logic                  out_free,
    output dnc_pkg::dnc_summary_t summary
);
    import dnc_pkg::*;

    localparam int LW        = $clog2(MAX_LABEL_LEN + 2);
    localparam int TW        = $clog2(TLD_MAX_CHARS + 2);
    localparam int TLD_STORE = (TLD_MAX_CHARS < 4) ? TLD_MAX_CHARS : 4;

    // Input stage
    logic          s1_valid_reg, s1_valid_next;
    char_t         s1_char_reg;
    logic          s1_last_reg;
    logic          advance;

    // Per-name state
    logic [1:0]    pc_reg, pc_next, pc_upd;
    logic [LW-1:0] len_reg, len_next, len_upd;
    logic          err_reg, err_next, err_upd;
    logic          dash_reg, dash_next;
    logic          start_reg, start_next;
    word_t         word_reg, word_next, word_upd;
    logic [TW-1:0] tl_reg, tl_next, tl_upd;

    // Byte classification
    char_t         lc;
    logic          is_dash, is_period, is_alnum;

    // Advance unless a last byte waits on a full result register
    assign advance      = s1_valid_reg && (!s1_last_reg || out_free);
    assign chars.ready  = !s1_valid_reg || advance;

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (chars.ready)
        begin
            s1_valid_next = chars.valid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
        end
    end

    // Capture byte payload
    always_ff @(posedge clk)
    begin
        if (chars.valid && chars.ready)
        begin
            s1_char_reg <= chars.char_in;
            s1_last_reg <= chars.last_char;
        end
    end

    // Fold case and classify
    always_comb
    begin
        lc = s1_char_reg;
        if ((s1_char_reg >= CH_UPPER_A) && (s1_char_reg <= CH_UPPER_Z))
        begin
            lc = s1_char_reg | CASE_BIT;
        end
        is_dash   = (lc == CH_DASH);
        is_period = (lc == CH_PERIOD);
        is_alnum  = ((lc >= CH_LOWER_A) && (lc <= CH_LOWER_Z)) ||
                    ((lc >= CH_DIGIT_0) && (lc <= CH_DIGIT_9));
    end

    // Apply the byte to the name state
    always_comb
    begin
        pc_upd   = pc_reg;
        len_upd  = len_reg;
        err_upd  = err_reg;
        word_upd = word_reg;
        tl_upd   = tl_reg;
        if (is_period)
        begin
            if (start_reg || dash_reg || (pc_reg != 2'd0))
            begin
                err_upd = 1'b1;
            end
            if (pc_reg != 2'd2)
            begin
                pc_upd = pc_reg + 2'd1;
            end
        end
        else if (pc_reg == 2'd0)
        begin
            if (!is_alnum && !is_dash)
            begin
                err_upd = 1'b1;
            end
            if (start_reg && is_dash)
            begin
                err_upd = 1'b1;
            end
            if (len_reg <= LW'(MAX_LABEL_LEN))
            begin
                len_upd = len_reg + LW'(1);
            end
        end
        else
        begin
            if (!is_alnum)
            begin
                err_upd = 1'b1;
            end
            // Place the byte first-char-high in the TLD word
            for (int k = 0; k < 4; k++)
            begin
                if ((k < TLD_STORE) && (tl_reg == TW'(k)))
                begin
                    word_upd[WORD_W-1-CHAR_W*k -: CHAR_W] = lc;
                end
            end
            if (tl_reg <= TW'(TLD_MAX_CHARS))
            begin
                tl_upd = tl_reg + TW'(1);
            end
        end
    end

    // Next state: clear after the last byte
    always_comb
    begin
        pc_next    = pc_reg;
        len_next   = len_reg;
        err_next   = err_reg;
        dash_next  = dash_reg;
        start_next = start_reg;
        word_next  = word_reg;
        tl_next    = tl_reg;
        if (advance)
        begin
            if (s1_last_reg)
            begin
                pc_next    = 2'd0;
                len_next   = '0;
                err_next   = 1'b0;
                dash_next  = 1'b0;
                start_next = 1'b1;
                word_next  = '0;
                tl_next    = '0;
            end
            else
            begin
                pc_next    = pc_upd;
                len_next   = len_upd;
                err_next   = err_upd;
                dash_next  = is_dash;
                start_next = 1'b0;
                word_next  = word_upd;
                tl_next    = tl_upd;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg    <= 2'd0;
            len_reg   <= '0;
            err_reg   <= 1'b0;
            dash_reg  <= 1'b0;
            start_reg <= 1'b1;
            word_reg  <= '0;
            tl_reg    <= '0;
        end
        else
        begin
            pc_reg    <= pc_next;
            len_reg   <= len_next;
            err_reg   <= err_next;
            dash_reg  <= dash_next;
            start_reg <= start_next;
            word_reg  <= word_next;
            tl_reg    <= tl_next;
        end
    end

    // Verdict on the name closed by this byte
    always_comb
    begin
        summary.fire      = advance && s1_last_reg;
        summary.name_ok   = !err_upd && (pc_upd == 2'd1) && !is_period &&
                            (len_upd != '0) && (len_upd <= LW'(MAX_LABEL_LEN)) &&
                            (tl_upd != '0);
        summary.matchable = summary.name_ok && (tl_upd <= TW'(TLD_STORE));
        summary.tld_word  = word_upd;
    end

`ifndef ASSERT_OFF
    a_clear_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        summary.fire |=> (start_reg && (pc_reg == 2'd0) && (tl_reg == '0)))
        else $error("name state not cleared after last byte");
    a_pc_saturates: assert property (@(posedge clk) disable iff (!rst_n)
        pc_reg != 2'd3)
        else $error("period count above saturation");
    a_hold_when_blocked: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && !advance) |=> (s1_valid_reg && $stable(s1_char_reg)))
        else $error("input stage lost a blocked byte");
`endif

endmodule

@@ rtl/core/dnc_tld_match.sv @@
// ----------------------------------------------------------------------------
// dnc_tld_match
// Compares the collected TLD word with the configured core and restricted
// words; core wins over restricted, empty slots never match.
// ----------------------------------------------------------------------------
module dnc_tld_match (
    input  dnc_pkg::word_t      cfg_words [dnc_pkg::NUM_CFG],
    input  dnc_pkg::word_t      tld_word,
    input  logic                matchable,
    output dnc_pkg::tld_class_t tld_class
);
    import dnc_pkg::*;

    logic [NUM_CFG-1:0] hit;
    logic               core_hit, restr_hit;

    // Match each slot in parallel
    always_comb
    begin
        for (int i = 0; i < NUM_CFG; i++)
        begin
            hit[i] = (cfg_words[i] != '0) && (cfg_words[i] == tld_word);
        end
    end

    assign core_hit  = |hit[NUM_CORE-1:0];
    assign restr_hit = |hit[NUM_CFG-1:NUM_CORE];

    // Pick the class
    always_comb
    begin
        tld_class = TLD_OTHER;
        if (matchable && core_hit)
        begin
            tld_class = TLD_CORE;
        end
        else if (matchable && restr_hit)
        begin
            tld_class = TLD_RESTRICTED;
        end
    end

endmodule

@@ tb/dnc_verdict_pkg.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// dnc_verdict_pkg
// Expected-verdict scoreboard for the domain name checker. Tracks the
// per-name syntax state and the TLD registers, queues the verdict that
// each last byte causes and compares results against it in order.
// ----------------------------------------------------------------------------
package dnc_verdict_pkg;

    import dnc_pkg::*;

    localparam int LABEL_MAX     = 63;
    localparam int TLD_CHARS_MAX = 4;
    localparam int STORE_CHARS   = (TLD_CHARS_MAX < 4) ? TLD_CHARS_MAX : 4;

    typedef struct packed {
        logic       name_valid;
        logic [1:0] tld_class;
    } verdict_t;

    class domain_verdict_model;

        word_t      tld_words [NUM_CFG];
        verdict_t   due [$];
        int         mismatches;
        int         names_seen;
        int         valid_seen;
        int         core_seen;
        int         restricted_seen;

        // Per-name syntax state
        logic [1:0] period_count;
        logic [6:0] label_len;
        logic       had_error;
        logic       last_dash;
        logic       at_start;
        word_t      tld_acc;
        logic [2:0] tld_len;

        function new();
            foreach (tld_words[i])
                tld_words[i] = CFG_RESET[i];
            mismatches      = 0;
            names_seen      = 0;
            valid_seen      = 0;
            core_seen       = 0;
            restricted_seen = 0;
            clear_name();
        endfunction

        function void clear_name();
            period_count = '0;
            label_len    = '0;
            had_error    = 1'b0;
            last_dash    = 1'b0;
            at_start     = 1'b1;
            tld_acc      = '0;
            tld_len      = '0;
        endfunction

        function void set_word(cfg_index_t idx, word_t w);
            tld_words[idx] = w;
        endfunction

        function int pending();
            return due.size();
        endfunction

        // Advance the name state by one accepted byte; queue a verdict on the last one
        function void take_char(char_t raw, logic last);
            char_t      c;
            logic       dash;
            logic       period;
            logic       alnum;
            logic       ok;
            tld_class_t cls;
            verdict_t   v;

            c = raw;
            if (c >= CH_UPPER_A && c <= CH_UPPER_Z)
                c = c | CASE_BIT;
            dash   = (c == CH_DASH);
            period = (c == CH_PERIOD);
            alnum  = (c >= CH_LOWER_A && c <= CH_LOWER_Z) ||
                     (c >= CH_DIGIT_0 && c <= CH_DIGIT_9);

            if (period)
            begin
                if (at_start || last_dash || period_count >= 1)
                    had_error = 1'b1;
                if (period_count < 2)
                    period_count++;
            end
            else if (period_count == 0)
            begin
                // Second-level label: letters, digits, dash, no leading dash
                if (!alnum && !dash)
                    had_error = 1'b1;
                if (at_start && dash)
                    had_error = 1'b1;
                if (label_len <= LABEL_MAX)
                    label_len++;
            end
            else
            begin
                // TLD: letters and digits only, packed from the top byte down
                if (!alnum)
                    had_error = 1'b1;
                if (tld_len < STORE_CHARS)
                    tld_acc = tld_acc | (word_t'(c) << (24 - 8 * int'(tld_len)));
                if (tld_len <= TLD_CHARS_MAX)
                    tld_len++;
            end
            last_dash = dash;
            at_start  = 1'b0;

            if (!last)
                return;

            ok = !had_error && period_count == 1 && !period &&
                 label_len >= 1 && label_len <= LABEL_MAX && tld_len >= 1;
            cls = TLD_OTHER;
            if (ok && tld_len <= STORE_CHARS)
            begin
                // Core words take precedence over restricted ones
                for (int i = 0; i < NUM_CORE; i++)
                    if (tld_words[i] != '0 && tld_words[i] == tld_acc)
                        cls = TLD_CORE;
                if (cls == TLD_OTHER)
                    for (int i = NUM_CORE; i < NUM_CFG; i++)
                        if (tld_words[i] != '0 && tld_words[i] == tld_acc)
                            cls = TLD_RESTRICTED;
            end
            v.name_valid = ok;
            v.tld_class  = cls;
            due.push_back(v);
            names_seen++;
            if (ok)
                valid_seen++;
            if (cls == TLD_CORE)
                core_seen++;
            if (cls == TLD_RESTRICTED)
                restricted_seen++;
            clear_name();
        endfunction

        // Compare one accepted result with the oldest queued verdict
        function void match_verdict(logic name_valid, logic [1:0] tld_class);
            verdict_t v;

            if (due.size() == 0)
            begin
                mismatches++;
                $display("%0t: result with no name pending, got name_valid=%0d tld_class=%0d",
                         $time, name_valid, tld_class);
                return;
            end
            v = due.pop_front();
            if (name_valid !== v.name_valid)
            begin
                mismatches++;
                $display("%0t: name_valid expected %0d, got %0d",
                         $time, v.name_valid, name_valid);
            end
            if (tld_class !== v.tld_class)
            begin
                mismatches++;
                $display("%0t: tld_class expected %0d, got %0d",
                         $time, v.tld_class, tld_class);
            end
        endfunction

    endclass

endpackage

@@ tb/tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Testbench for the domain name checker. Streams directed and random
// names under random idling on both channels, rewrites the TLD registers
// between phases and checks every verdict against the scoreboard.
// ----------------------------------------------------------------------------
module tb;

    import dnc_pkg::*;
    import dnc_verdict_pkg::*;

    localparam int LIMIT_CYCLES  = 200000;
    localparam int HOLD_CYCLES   = 200;
    localparam int SETTLE_CYCLES = 4;

    logic           clk = 1'b0;
    logic           rst_n;
    logic           cfg_wr_en;
    cfg_index_t     cfg_index;
    word_t          cfg_wdata;

    dnc_char_if     chars_if ();
    dnc_result_if   results_if ();

    domain_verdict_model verdicts;

    char_t          name_buf [$];
    word_t          setting [NUM_CFG];
    int             bytes_sent;
    int             settings_loaded;
    int             cycle_count;
    bit             tx_fast;
    bit             hold_off_request;
    bit             held_off;

    // Clock: 10 ns period
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    domain_name_checker i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .chars     (chars_if),
        .results   (results_if),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    // Watchdog: end the run if it hangs
    initial
    begin
        cycle_count = 0;
        while (cycle_count < LIMIT_CYCLES)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("Timeout after %0d cycles, %0d verdicts outstanding",
                 cycle_count, verdicts.pending());
        $display("Mismatches found");
        $finish;
    end

    // Result side: random stalls, bursts with ready held high, one long hold-off
    initial
    begin : result_sink
        int gap;
        int burst_left;

        results_if.ready = 1'b0;
        burst_left = 0;
        @(posedge rst_n);
        @(negedge clk);
        forever
        begin
            if (hold_off_request)
            begin
                hold_off_request = 1'b0;
                held_off = 1'b1;
                results_if.ready = 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
            end
            if (burst_left > 0)
            begin
                burst_left--;
                gap = 0;
            end
            else
            begin
                gap = $urandom_range(0, 19);
                if ($urandom_range(0, 7) == 0)
                    burst_left = $urandom_range(10, 30);
            end
            if (gap > 0)
            begin
                results_if.ready = 1'b0;
                repeat (gap) @(negedge clk);
            end
            results_if.ready = 1'b1;
            do
                @(posedge clk);
            while (results_if.valid !== 1'b1);
            verdicts.match_verdict(results_if.name_valid, results_if.tld_class);
            @(negedge clk);
        end
    end

    function automatic char_t mixed_case(char_t c);
        if (c >= CH_LOWER_A && c <= CH_LOWER_Z && $urandom_range(0, 1) == 1)
            return c & ~CASE_BIT;
        return c;
    endfunction

    function automatic char_t random_alnum();
        int r;

        r = $urandom_range(0, 35);
        if (r < 26)
            return mixed_case(CH_LOWER_A + char_t'(r));
        return CH_DIGIT_0 + char_t'(r - 26);
    endfunction

    function automatic word_t tld_pack(string s);
        word_t w;

        w = '0;
        for (int i = 0; i < s.len() && i < 4; i++)
            w[31 - 8 * i -: 8] = s[i];
        return w;
    endfunction

    // Build one name into name_buf: mostly well-formed, some broken, some noise
    function automatic void build_random_name(int forced_len);
        int    kind;
        int    len;
        int    pick;
        word_t w;
        char_t c;

        name_buf.delete();
        kind = (forced_len > 0) ? 0 : $urandom_range(0, 99);
        if (kind >= 90)
        begin
            len = $urandom_range(1, 12);
            repeat (len)
                name_buf.push_back(($urandom_range(0, 3) == 0) ?
                                   CH_PERIOD : char_t'($urandom_range(0, 255)));
            return;
        end

        // Label with inner dashes only
        pick = $urandom_range(0, 99);
        if (forced_len > 0)
            len = forced_len;
        else if (pick < 85)
            len = $urandom_range(1, 8);
        else if (pick < 95)
            len = $urandom_range(9, 62);
        else
            len = $urandom_range(63, 64);
        for (int k = 0; k < len; k++)
            if (k > 0 && k < len - 1 && $urandom_range(0, 4) == 0)
                name_buf.push_back(CH_DASH);
            else
                name_buf.push_back(random_alnum());
        name_buf.push_back(CH_PERIOD);

        // TLD: often a configured word, else random letters and digits
        pick = $urandom_range(0, NUM_CFG + 2);
        if (pick < NUM_CFG && verdicts.tld_words[pick] != '0)
        begin
            w = verdicts.tld_words[pick];
            for (int b = 0; b < 4; b++)
            begin
                c = w[31 - 8 * b -: 8];
                if (c == '0)
                    break;
                name_buf.push_back(mixed_case(c));
            end
        end
        if (name_buf.size() == len + 1)
            repeat ($urandom_range(1, 6))
                name_buf.push_back(random_alnum());

        // Break a well-formed name in one place
        if (kind >= 75)
            case ($urandom_range(0, 6))
                0: name_buf.push_front(CH_DASH);
                1: name_buf.insert(len, CH_DASH);
                2: name_buf.insert($urandom_range(0, name_buf.size()), CH_PERIOD);
                3: repeat (len) void'(name_buf.pop_front());
                4: while (name_buf.size() > len + 1) void'(name_buf.pop_back());
                5: name_buf[$urandom_range(0, name_buf.size() - 1)] = char_t'($urandom_range(0, 255));
                default: name_buf.delete(len);
            endcase
    endfunction

    // Offer name_buf byte by byte; each item waits for its handshake
    task automatic send_name();
        int gap;

        for (int k = 0; k < name_buf.size(); k++)
        begin
            gap = tx_fast ? 0 : $urandom_range(0, 19);
            if (gap > 0)
            begin
                chars_if.valid = 1'b0;
                repeat (gap) @(negedge clk);
            end
            chars_if.valid     = 1'b1;
            chars_if.char_in   = name_buf[k];
            chars_if.last_char = (k == name_buf.size() - 1);
            do
                @(posedge clk);
            while (chars_if.ready !== 1'b1);
            verdicts.take_char(chars_if.char_in, chars_if.last_char);
            bytes_sent++;
            @(negedge clk);
        end
    endtask

    task automatic send_text(string s);
        name_buf.delete();
        for (int i = 0; i < s.len(); i++)
            name_buf.push_back(s[i]);
        send_name();
    endtask

    task automatic run_random(int budget, bit fast);
        int start;

        start = bytes_sent;
        while (bytes_sent - start < budget)
        begin
            tx_fast = fast || ($urandom_range(0, 5) == 0);
            build_random_name(0);
            send_name();
        end
    endtask

    // Drop valid and wait until every verdict is back and the pipe is empty
    task automatic settle_idle();
        chars_if.valid = 1'b0;
        while (verdicts.pending() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    // Write all seven TLD registers from setting[]
    task automatic load_setting();
        for (int i = 0; i < NUM_CFG; i++)
        begin
            cfg_wr_en = 1'b1;
            cfg_index = cfg_index_t'(i);
            cfg_wdata = setting[i];
            @(negedge clk);
            verdicts.set_word(cfg_index_t'(i), setting[i]);
        end
        cfg_wr_en = 1'b0;
        settings_loaded++;
    endtask

    initial
    begin
        string directed [];

        directed = '{"A.Org", "9.pRo", "b-c.INFO", "x.name", ".io", "a.",
                     "-.x", "a-.b", "a..b", "ab", "a.infos", "z.x-", "."};
        verdicts = new();
        rst_n              = 1'b0;
        cfg_wr_en          = 1'b0;
        cfg_index          = CFG_CORE_TLD_0;
        cfg_wdata          = '0;
        chars_if.valid     = 1'b0;
        chars_if.char_in   = '0;
        chars_if.last_char = 1'b0;
        bytes_sent         = 0;
        settings_loaded    = 0;
        tx_fast            = 1'b0;
        hold_off_request   = 1'b0;
        held_off           = 1'b0;

        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Directed names against the reset words
        foreach (directed[i])
            send_text(directed[i]);
        name_buf.delete();
        name_buf.push_back(CH_LOWER_A);
        name_buf.push_back(8'h00);
        name_buf.push_back(CH_PERIOD);
        name_buf.push_back(8'hFF);
        send_name();

        // Longest legal label and one past it
        build_random_name(63);
        send_name();
        build_random_name(64);
        send_name();
        run_random(130, 1'b0);
        settle_idle();

        // All slots empty: nothing matches
        foreach (setting[i])
            setting[i] = '0;
        load_setting();
        run_random(110, 1'b0);
        settle_idle();

        // All ones
        foreach (setting[i])
            setting[i] = '1;
        load_setting();
        run_random(110, 1'b0);
        settle_idle();

        // Short words, a full four-character word, a word listed in both classes
        setting[CFG_CORE_TLD_0]       = tld_pack("a");
        setting[CFG_CORE_TLD_1]       = tld_pack("io");
        setting[CFG_CORE_TLD_2]       = tld_pack("x9z");
        setting[CFG_CORE_TLD_3]       = tld_pack("dev0");
        setting[CFG_RESTRICTED_TLD_0] = tld_pack("io");
        setting[CFG_RESTRICTED_TLD_1] = tld_pack("zz");
        setting[CFG_RESTRICTED_TLD_2] = tld_pack("7");
        load_setting();
        run_random(130, 1'b0);
        settle_idle();

        // Random words: empty, raw bits, or lower-case letters and digits
        foreach (setting[i])
        begin
            case ($urandom_range(0, 3))
                0: setting[i] = '0;
                1: setting[i] = word_t'($urandom);
                default:
                begin
                    setting[i] = '0;
                    for (int b = 0; b < $urandom_range(1, 4); b++)
                        setting[i][31 - 8 * b -: 8] = random_alnum() | CASE_BIT;
                end
            endcase
        end
        load_setting();
        run_random(130, 1'b0);
        settle_idle();

        // Back to the defaults, back-to-back bytes while the result side holds off
        foreach (setting[i])
            setting[i] = CFG_RESET[i];
        load_setting();
        hold_off_request = 1'b1;
        run_random(110, 1'b1);
        settle_idle();
        repeat (SETTLE_CYCLES) @(negedge clk);

        $display("Checked %0d names from %0d bytes: %0d valid, %0d core, %0d restricted",
                 verdicts.names_seen, bytes_sent, verdicts.valid_seen,
                 verdicts.core_seen, verdicts.restricted_seen);
        $display("Register settings loaded: %0d, long result hold-off: %0d",
                 settings_loaded, held_off);
        if (verdicts.mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
